[sv/bitmap_first_fit_allocator_assert.svh]
// assertion macros for the bitmap first-fit allocator
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH

// same-cycle implication, off while reset is high
`define BFFA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bffa assertion failed");

// next-cycle implication, off while reset is high
`define BFFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bffa assertion failed");

`endif

[sv/bffa_pkg.sv]
// package: sizes, codes, controller types and helper functions of the allocator
package bffa_pkg;

   localparam int NUM_BLOCKS = 65536;

   // bitmap word and summary geometry
   localparam int WBITS      = 6;
   localparam int WORD_W     = 1 << WBITS;
   localparam int NUM_WORDS  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int NUM_GROUPS = (NUM_WORDS + WORD_W - 1) / WORD_W;
   localparam int GAW        = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int WORD_AW    = GAW + WBITS;
   localparam int BM_DEPTH   = NUM_GROUPS * WORD_W;
   localparam int BLK_W      = GAW + 2 * WBITS;
   localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

   // field widths
   localparam int IDX_W       = 16;
   localparam int COUNT_W     = 17;
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_A_GRP,
      S_A_WORD,
      S_A_BIT,
      S_F_CHK,
      S_F_UPD,
      S_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic a_grp;
      logic a_word;
      logic a_bit;
      logic f_chk;
      logic f_upd;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic map_full;
      logic idx_bad;
      logic out_free;
   } sts_type;

   // lowest clear bit of a bitmap word
   function automatic logic [WBITS-1:0] first_zero_bit(input logic [WORD_W-1:0] v);
      logic [WBITS-1:0] r;
      r = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!v[i]) begin
            r = WBITS'(i);
         end
      end
      return r;
   endfunction

   // lowest group that still has a free word
   function automatic logic [GAW-1:0] first_zero_grp(input logic [NUM_GROUPS-1:0] v);
      logic [GAW-1:0] r;
      r = '0;
      for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
         if (!v[i]) begin
            r = GAW'(i);
         end
      end
      return r;
   endfunction

endpackage

[sv/bffa_ctrl.sv]
// controller state machine of the allocator
module bffa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_op,
   input  bffa_pkg::sts_type sts,
   output logic             req_tready,
   output bffa_pkg::cmd_type cmd
);
   import bffa_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) state_in = (req_op == OP_FREE) ? S_F_CHK : S_A_GRP;
         end
         S_A_GRP: begin
            state_in = sts.map_full ? S_OUT : S_A_WORD;
         end
         S_A_WORD: state_in = S_A_BIT;
         S_A_BIT:  state_in = S_OUT;
         S_F_CHK: begin
            state_in = sts.idx_bad ? S_OUT : S_F_UPD;
         end
         S_F_UPD:  state_in = S_OUT;
         S_OUT: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default:  state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_CLEAR:  cmd.clear = 1'b1;
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         S_A_GRP:  cmd.a_grp  = 1'b1;
         S_A_WORD: cmd.a_word = 1'b1;
         S_A_BIT:  cmd.a_bit  = 1'b1;
         S_F_CHK:  cmd.f_chk  = 1'b1;
         S_F_UPD:  cmd.f_upd  = 1'b1;
         S_OUT:    cmd.out_load = sts.out_free;
         default:  cmd = '0;
      endcase
   end

endmodule

[sv/bffa_dp.sv]
// datapath: bitmap and summary memories, group flags, free count, result register
`include "bitmap_first_fit_allocator_assert.svh"

module bffa_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  bffa_pkg::cmd_type                  cmd,
   output bffa_pkg::sts_type                  sts,
   input  logic [bffa_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bffa_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic [bffa_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);
   import bffa_pkg::*;

   // memories: bitmap words and per-group word-full flags
   logic [WORD_W-1:0] bm_mem [BM_DEPTH];
   logic [WORD_W-1:0] l1_mem [NUM_GROUPS];

   logic [WORD_W-1:0]     bm_rd_ff;
   logic [WORD_W-1:0]     l1_rd_ff;
   logic [NUM_GROUPS-1:0] l2_ff, l2_in;
   logic [CNT_W-1:0]      free_total_ff, free_total_in;
   logic [WORD_AW-1:0]    clr_cnt_ff, clr_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0]   idx_ff;
   logic [GAW-1:0]     grp_ff;
   logic [WBITS-1:0]   wrd_ff;
   logic [WBITS-1:0]   bit_ff;
   logic [IDX_W-1:0]   res_granted_ff;
   status_type         res_status_ff;
   logic [IDX_W-1:0]   rsp_granted_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   status_type         rsp_status_ff;

   logic [GAW-1:0]    grp_pick;
   logic [WBITS-1:0]  wrd_pick;
   logic [WBITS-1:0]  bit_pick;
   logic [BLK_W-1:0]  idx_blk;
   logic [GAW-1:0]    idx_grp;
   logic [WBITS-1:0]  idx_wrd;
   logic [WBITS-1:0]  idx_bit;
   logic              idx_bad;
   logic [WORD_W-1:0] bm_set, bm_clr, l1_set, l1_clr;
   logic              word_full, bit_was;
   logic [GAW-1:0]    clr_grp;
   logic [WORD_W-1:0] clr_word, clr_l1;

   logic               bm_we, bm_re, l1_we, l1_re;
   logic [WORD_AW-1:0] bm_waddr, bm_raddr;
   logic [GAW-1:0]     l1_waddr, l1_raddr;
   logic [WORD_W-1:0]  bm_wdata, l1_wdata;

   assign grp_pick = first_zero_grp(l2_ff);
   assign wrd_pick = first_zero_bit(l1_rd_ff);
   assign bit_pick = first_zero_bit(bm_rd_ff);

   assign idx_blk = BLK_W'(idx_ff);
   assign idx_grp = idx_blk[BLK_W-1 -: GAW];
   assign idx_wrd = idx_blk[2*WBITS-1:WBITS];
   assign idx_bit = idx_blk[WBITS-1:0];
   assign idx_bad = (32'(idx_ff) >= 32'(NUM_BLOCKS));

   // allocate: set the picked bit, flag the word if it filled up
   assign bm_set    = bm_rd_ff | (WORD_W'(1) << bit_pick);
   assign word_full = &bm_set;
   assign l1_set    = l1_rd_ff | (word_full ? (WORD_W'(1) << wrd_ff) : '0);

   // free: clear the bit and the word's full flag
   assign bit_was = bm_rd_ff[bit_ff];
   assign bm_clr  = bm_rd_ff & ~(WORD_W'(1) << bit_ff);
   assign l1_clr  = l1_rd_ff & ~(WORD_W'(1) << wrd_ff);

   // clearing pass: bits past the last block and words past the last word start used
   assign clr_grp = clr_cnt_ff[GAW-1:0];
   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         clr_word[i] = (32'({clr_cnt_ff, WBITS'(i)}) >= 32'(NUM_BLOCKS));
         clr_l1[i]   = (32'({clr_grp, WBITS'(i)}) >= 32'(NUM_WORDS));
      end
   end

   always_comb begin
      bm_we    = 1'b0;
      bm_waddr = {grp_ff, wrd_ff};
      bm_wdata = bm_set;
      l1_we    = 1'b0;
      l1_waddr = grp_ff;
      l1_wdata = l1_set;
      priority if (cmd.clear) begin
         bm_we    = 1'b1;
         bm_waddr = clr_cnt_ff;
         bm_wdata = clr_word;
         l1_we    = 1'b1;
         l1_waddr = clr_grp;
         l1_wdata = clr_l1;
      end else if (cmd.a_bit) begin
         bm_we = 1'b1;
         l1_we = word_full;
      end else if (cmd.f_upd) begin
         bm_we    = bit_was;
         bm_wdata = bm_clr;
         l1_we    = bit_was;
         l1_wdata = l1_clr;
      end else begin
         bm_we = 1'b0;
         l1_we = 1'b0;
      end
   end

   assign bm_re    = cmd.a_word | cmd.f_chk;
   assign bm_raddr = cmd.a_word ? {grp_ff, wrd_pick} : {idx_grp, idx_wrd};
   assign l1_re    = cmd.a_grp | cmd.f_chk;
   assign l1_raddr = cmd.a_grp ? grp_pick : idx_grp;

   always_ff @(posedge clock) begin
      if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
      if (bm_re) bm_rd_ff <= bm_mem[bm_raddr];
   end

   always_ff @(posedge clock) begin
      if (l1_we) l1_mem[l1_waddr] <= l1_wdata;
      if (l1_re) l1_rd_ff <= l1_mem[l1_raddr];
   end

   always_comb begin
      clr_cnt_in    = cmd.clear ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      l2_in         = l2_ff;
      free_total_in = free_total_ff;
      if (cmd.a_bit) begin
         free_total_in = free_total_ff - 1'b1;
         if (&l1_set) l2_in[grp_ff] = 1'b1;
      end else if (cmd.f_upd && bit_was) begin
         free_total_in  = free_total_ff + 1'b1;
         l2_in[grp_ff]  = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff    <= '0;
         l2_ff         <= '0;
         free_total_ff <= CNT_W'(NUM_BLOCKS);
         rsp_valid_ff  <= 1'b0;
      end else begin
         clr_cnt_ff    <= clr_cnt_in;
         l2_ff         <= l2_in;
         free_total_ff <= free_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // request, walk position and pending result
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff         <= req_tdata[IDX_W-1:0];
         res_granted_ff <= '0;
         res_status_ff  <= ST_DONE;
      end
      if (cmd.a_grp) begin
         grp_ff <= grp_pick;
         if (sts.map_full) res_status_ff <= ST_FULL;
      end
      if (cmd.a_word) wrd_ff <= wrd_pick;
      if (cmd.a_bit) begin
         bit_ff         <= bit_pick;
         res_granted_ff <= IDX_W'({grp_ff, wrd_ff, bit_pick});
      end
      if (cmd.f_chk) begin
         grp_ff <= idx_grp;
         wrd_ff <= idx_wrd;
         bit_ff <= idx_bit;
         if (idx_bad) res_status_ff <= ST_RANGE;
      end
      if (cmd.out_load) begin
         rsp_granted_ff <= res_granted_ff;
         rsp_status_ff  <= res_status_ff;
         rsp_count_ff   <= COUNT_W'(free_total_ff);
      end
   end

   assign sts.clr_last = (clr_cnt_ff == WORD_AW'(BM_DEPTH - 1));
   assign sts.map_full = &l2_ff;
   assign sts.idx_bad  = idx_bad;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - COUNT_W - IDX_W)'(0), rsp_count_ff, rsp_granted_ff};
   assign rsp_tuser  = rsp_status_ff;

   `BFFA_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, free_total_ff <= CNT_W'(NUM_BLOCKS))
   `BFFA_ASSERT_IMPL(a_pick_is_free, clock, reset, cmd.a_bit, !bm_rd_ff[bit_pick])
   `BFFA_ASSERT_IMPL(a_load_slot_free, clock, reset, cmd.out_load, !rsp_valid_ff || rsp_tready)
   `BFFA_ASSERT_NEXT(a_alloc_takes_one, clock, reset, cmd.a_bit,
                     free_total_ff == $past(free_total_ff) - 1'b1)

endmodule

[sv/bitmap_first_fit_allocator.sv]
// top level of the bitmap first-fit block allocator
//
// keeps one used/free bit per block (NUM_BLOCKS blocks, 65536 by default) in a
// 64-bit-wide bitmap memory, a second memory holding one "word full" flag per
// bitmap word, and a register of per-group "all words full" flags, plus a count
// of free blocks. an allocate beat (req_tuser opcode 0) walks the summary:
// lowest group with room, lowest word with room, lowest clear bit; it sets that
// bit and returns the block index with status done, or status full when every
// block is used. a free beat (opcode 1) clears the named block; the count only
// rises if the bit was set, and an index at or past NUM_BLOCKS is answered
// with status range and changes nothing. every request beat gives exactly one
// response beat, carrying the free count after the request.
// timing: one request at a time; an allocate walk makes two registered memory
// reads (summary word, then bitmap word) before it sets the bit. the response
// sits in an output register, so the next request is taken while a response
// still waits on rsp_tready.
// after reset a clearing pass over all 1024 bitmap words (one per cycle) runs
// with req_tready low.
module bitmap_first_fit_allocator (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bffa_pkg::REQ_TDATA_W-1:0]   req_tdata,   // [15:0] block_index
   input  logic [bffa_pkg::REQ_TUSER_W-1:0]   req_tuser,   // [0] opcode
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bffa_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // [15:0] granted_index,
                                                            // [32:16] free_count
   output logic [bffa_pkg::RSP_TUSER_W-1:0]   rsp_tuser    // [1:0] status
);
   import bffa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer: clearing pass, allocate walk, free update, response hand-off
   bffa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser[0]),
      .sts        (sts),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   // memories, summary flags, free count and the response register
   bffa_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[dv/tb_bitmap_first_fit_allocator.sv]
// testbench for the bitmap first-fit allocator: directed table, then random traffic
`timescale 1ns / 100ps

module tb_bitmap_first_fit_allocator;
   import bffa_pkg::*;

   // predictor geometry: one used bit per block, eight to a byte
   localparam int          MAP_BYTES   = (NUM_BLOCKS + 7) / 8;
   localparam logic [7:0]  FULL_BYTE   = 8'hFF;
   localparam int          CYCLE_LIMIT = 2000000;
   localparam int          LONG_HOLD   = 600;
   localparam int          DRAIN_TAIL  = 20;

   // one response beat as the block should send it
   typedef struct packed {
      logic [IDX_W-1:0]   granted;
      status_type         status;
      logic [COUNT_W-1:0] count;
   } alloc_result_type;

   // one row of the directed table; typed rows carry their answer
   typedef struct packed {
      logic             op;
      logic [15:0]      idx;
      logic             typed;
      alloc_result_type res;
   } stim_row_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata  = '0;    // [15:0] block_index
   logic [REQ_TUSER_W-1:0]  req_tuser  = '0;    // [0] opcode
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;          // [15:0] granted_index, [32:16] free_count
   logic [RSP_TUSER_W-1:0]  rsp_tuser;          // [1:0] status

   // predictor state
   logic [7:0]    used_bytes [MAP_BYTES];
   int unsigned   shadow_free_count;
   int unsigned   scan_floor;    // every byte below this one is full

   alloc_result_type awaited_results [$];

   // run control
   bit            req_gaps_on = 1'b1;
   bit            rsp_gaps_on = 1'b1;
   int            stall_asks  = 0;
   int            stall_grants = 0;
   int            rsp_wait    = 0;
   int            cycle_count = 0;
   int            error_count = 0;

   // coverage tallies for the summary
   int            count_alloc  = 0;
   int            count_full   = 0;
   int            count_free   = 0;
   int            count_double = 0;
   int            count_range  = 0;
   int            count_checked = 0;

   // directed rows, typed answers assume the default size and a fresh map
   stim_row_type directed_rows [24] = '{
      '{OP_ALLOC, 16'h0000, 1'b1, '{16'd0, ST_DONE, 17'd65535}},   // first grant after reset
      '{OP_ALLOC, 16'hFFFF, 1'b1, '{16'd1, ST_DONE, 17'd65534}},   // index ignored on allocate
      '{OP_ALLOC, 16'h0000, 1'b1, '{16'd2, ST_DONE, 17'd65533}},
      '{OP_FREE,  16'h0001, 1'b1, '{16'd0, ST_DONE, 17'd65534}},
      '{OP_FREE,  16'h0001, 1'b1, '{16'd0, ST_DONE, 17'd65534}},   // double free
      '{OP_ALLOC, 16'h1234, 1'b1, '{16'd1, ST_DONE, 17'd65533}},   // hole is refilled first
      '{OP_FREE,  16'hFFFF, 1'b1, '{16'd0, ST_DONE, 17'd65533}},   // top block, never used
      '{OP_FREE,  16'h0000, 1'b1, '{16'd0, ST_DONE, 17'd65534}},
      '{OP_FREE,  16'h0002, 1'b1, '{16'd0, ST_DONE, 17'd65535}},
      '{OP_FREE,  16'h0001, 1'b1, '{16'd0, ST_DONE, 17'd65536}},   // count back at maximum
      '{OP_FREE,  16'h0000, 1'b1, '{16'd0, ST_DONE, 17'd65536}},   // double free, empty map
      '{OP_ALLOC, 16'h0000, 1'b1, '{16'd0, ST_DONE, 17'd65535}},
      '{OP_ALLOC, 16'h5555, 1'b0, '0},                             // walk across a byte edge
      '{OP_ALLOC, 16'hAAAA, 1'b0, '0},
      '{OP_ALLOC, 16'hFFFF, 1'b0, '0},
      '{OP_ALLOC, 16'h0001, 1'b0, '0},
      '{OP_ALLOC, 16'h8000, 1'b0, '0},
      '{OP_ALLOC, 16'h7FFF, 1'b0, '0},
      '{OP_ALLOC, 16'h00FF, 1'b0, '0},
      '{OP_ALLOC, 16'hFF00, 1'b0, '0},
      '{OP_FREE,  16'h0008, 1'b0, '0},                             // hole in the second byte
      '{OP_FREE,  16'h0003, 1'b0, '0},                             // lower hole in the first
      '{OP_ALLOC, 16'h5A5A, 1'b0, '0},
      '{OP_ALLOC, 16'hA5A5, 1'b0, '0}
   };

   bitmap_first_fit_allocator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // next answer of the allocator for one request, updating the shadow bitmap
   function automatic alloc_result_type next_allocator_result(input logic op,
                                                              input logic [15:0] idx);
      alloc_result_type r;
      int               found;
      int unsigned      byte_pos;
      int unsigned      blk;
      int unsigned      idx_u;
      r.granted = '0;
      r.status  = ST_DONE;
      if (op == OP_ALLOC) begin
         count_alloc++;
         // first fit, skipping full bytes; -2 marks the unusable tail of a partial byte
         found    = -1;
         byte_pos = scan_floor;
         while (found == -1 && byte_pos < MAP_BYTES) begin
            if (used_bytes[byte_pos] != FULL_BYTE) begin
               for (int b = 0; b < 8 && found == -1; b++) begin
                  blk = byte_pos * 8 + b;
                  if (blk >= NUM_BLOCKS) begin
                     found = -2;
                  end else if (!used_bytes[byte_pos][b]) begin
                     found = int'(blk);
                  end
               end
            end
            if (found == -1) begin
               byte_pos++;
            end
         end
         scan_floor = byte_pos;
         if (found >= 0) begin
            blk = found;
            used_bytes[blk >> 3][blk[2:0]] = 1'b1;
            if (shadow_free_count > 0) begin
               shadow_free_count--;
            end
            r.granted = blk[15:0];
         end else begin
            r.status = ST_FULL;
            count_full++;
         end
      end else begin
         count_free++;
         idx_u = 32'(idx);
         if (idx_u >= NUM_BLOCKS) begin
            r.status = ST_RANGE;
            count_range++;
         end else if (used_bytes[idx_u >> 3][idx_u[2:0]]) begin
            used_bytes[idx_u >> 3][idx_u[2:0]] = 1'b0;
            if (shadow_free_count < NUM_BLOCKS) begin
               shadow_free_count++;
            end
            if ((idx_u >> 3) < scan_floor) begin
               scan_floor = idx_u >> 3;
            end
         end else begin
            count_double++;
         end
      end
      r.count = shadow_free_count[COUNT_W-1:0];
      return r;
   endfunction

   // offer one request beat after a random gap; record its answer once accepted
   task automatic issue_request(input logic op, input logic [15:0] idx,
                                input logic typed, input alloc_result_type typed_res);
      int               gap;
      alloc_result_type predicted;
      gap = req_gaps_on ? $urandom_range(0, 7) : 0;
      // valid stays high between back-to-back beats, dropped only for a gap
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= idx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = next_allocator_result(op, idx);
      awaited_results.push_back(typed ? typed_res : predicted);
   endtask

   // random mix: low window hits recently used blocks, top window and repeats give
   // frees of blocks at the far end and double frees
   task automatic random_traffic(input int count);
      logic        op;
      logic [15:0] idx;
      logic [15:0] last_freed;
      int          pick;
      last_freed = '0;
      for (int n = 0; n < count; n++) begin
         // stretches with and without idling on either side
         if (n % 50 == 0) begin
            req_gaps_on  = ($urandom_range(0, 3) != 0);
            rsp_gaps_on <= ($urandom_range(0, 3) != 0);
         end
         op   = ($urandom_range(0, 99) < 45) ? OP_ALLOC : OP_FREE;
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            idx = 16'($urandom_range(0, 127));
         end else if (pick < 8) begin
            idx = 16'($urandom);
         end else if (pick < 9) begin
            idx = 16'($urandom_range(65408, 65535));
         end else begin
            idx = last_freed;
         end
         if (op == OP_FREE) begin
            last_freed = idx;
         end
         issue_request(op, idx, 1'b0, '0);
      end
   endtask

   // response side: check each beat against the oldest awaited answer, then
   // hold tready low for a random number of cycles, or a long stretch on request
   always @(posedge clock) begin
      alloc_result_type exp;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected beat: granted %0d status %0d count %0d",
                        $time, rsp_tdata[15:0], rsp_tuser, rsp_tdata[32:16]);
            end else begin
               exp = awaited_results.pop_front();
               count_checked++;
               if (rsp_tdata[15:0] !== exp.granted) begin
                  error_count++;
                  $display("%0t: granted_index expected %0d actual %0d",
                           $time, exp.granted, rsp_tdata[15:0]);
               end
               if (rsp_tuser !== exp.status) begin
                  error_count++;
                  $display("%0t: status expected %0d actual %0d", $time, exp.status, rsp_tuser);
               end
               if (rsp_tdata[32:16] !== exp.count) begin
                  error_count++;
                  $display("%0t: free_count expected %0d actual %0d",
                           $time, exp.count, rsp_tdata[32:16]);
               end
            end
            rsp_wait = rsp_gaps_on ? $urandom_range(0, 7) : 0;
         end
         // long hold-off so the output register fills and the block stalls its input
         if (stall_asks != stall_grants) begin
            stall_grants = stall_asks;
            rsp_wait     = LONG_HOLD;
         end
         if (rsp_wait > 0) begin
            rsp_tready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, awaited_results.size());
         $display("tb_bitmap_first_fit_allocator: errors");
         $finish;
      end
   end

   initial begin
      // shadow bitmap starts all free, matching the reset of the block
      for (int i = 0; i < MAP_BYTES; i++) begin
         used_bytes[i] = '0;
      end
      shadow_free_count = NUM_BLOCKS;
      scan_floor        = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table; the clearing pass after reset is absorbed by the handshake
      foreach (directed_rows[i]) begin
         issue_request(directed_rows[i].op, directed_rows[i].idx,
                       directed_rows[i].typed, directed_rows[i].res);
      end

      // random traffic on a mostly empty map
      random_traffic(263);

      // more random traffic, starting under a long receiver stall
      stall_asks <= stall_asks + 1;
      random_traffic(263);

      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);

      $display("covered %0d allocates (%0d answered full) and %0d frees",
               count_alloc, count_full, count_free);
      $display("  (%0d double, %0d out of range); compared %0d response beats over %0d cycles",
               count_double, count_range, count_checked, cycle_count);
      if (error_count == 0) begin
         $display("tb_bitmap_first_fit_allocator: clean");
      end else begin
         $display("tb_bitmap_first_fit_allocator: errors");
      end
      $finish;
   end

endmodule
